/* rtl/ffsa_pkg.sv */
`default_nettype none
package ffsa_pkg;
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int POOL_UNITS_DEF = 65536;
	localparam int SIZE_W = 17;
	localparam int OFF_W = 16;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE = 1'b1;

	// one table entry: size and used mark
	typedef struct packed {
		logic used;
		logic [SIZE_W-1:0] size;
	} seg_t;
endpackage
`default_nettype wire

/* rtl/first_fit_segment_allocator.sv */
`default_nettype none
// First-fit segment allocator. The pool of pool_size units is described by an
// address-ordered table of segments held in one synchronous memory. An allocate
// walks the table from entry zero, reading and checking each entry in turn, and
// takes the first free segment large enough; a remainder is split off by moving
// every later entry up one place. A free walks until the running offset matches,
// clears the used mark, then merges free neighbours in a pass over the whole
// table, moving later entries down. Every step uses the single memory port: an
// entry is read, then checked or written. A finished result waits in an output
// register, so the next transaction is taken while it is still held; only a
// second finished result stalls behind it. A write of pool_size reinitialises
// the table with a clearing pass, during which no transaction is accepted; a
// transaction accepted or in flight at that write is dropped without a result.
// The same pass runs after reset. Every other transaction yields exactly one
// result transaction.
module first_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
	parameter int POOL_UNITS = ffsa_pkg::POOL_UNITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic s_tvalid,
	output logic s_tready,
	// alloc_size [16:0], block_offset [32:17], zero [39:33]
	input wire logic [39:0] s_tdata,
	// func
	input wire logic s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// segment_offset [15:0], status [18:16], used_total [35:19], free_total [52:36], zero [55:53]
	output logic [55:0] m_tdata
);
	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int SW = ffsa_pkg::SIZE_W;
	localparam logic [SW:0] POOL_MAX = (SW+1)'(POOL_UNITS > 65536 ? 65536 : POOL_UNITS);

	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_CHK = 4'd3,
		S_SPL_RD = 4'd4, S_SPL_WR = 4'd5, S_SPL_FIN = 4'd6, S_MRG_RD = 4'd7,
		S_MRG_CHK = 4'd8, S_SH_RD = 4'd9, S_SH_WR = 4'd10, S_OUT = 4'd11;

	logic [3:0] state_q;
	logic [AW-1:0] idx_q, tgt_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] pool_q, used_q, req_q, acc_q;
	logic func_q;
	logic [ffsa_pkg::OFF_W-1:0] boff_q, res_off_q;
	logic [ffsa_pkg::STATUS_W-1:0] res_st_q;
	ffsa_pkg::seg_t prev_q, hold_q;
	logic prev_ok_q;
	logic [55:0] m_data_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	ffsa_pkg::seg_t wdata, rdata;

	ffsa_table #(.DEPTH(MAX_SEGMENTS), .AW(AW)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic cfg_wr;
	logic [SW-1:0] cfg_v;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = {{(32-SW){1'b0}}, pool_q};
	always_comb begin
		cfg_v = pwdata[SW-1:0];
		if (cfg_v == '0) cfg_v = SW'(1);
		if ({1'b0, cfg_v} > POOL_MAX) cfg_v = POOL_MAX[SW-1:0];
	end

	// result register frees the input side while a result waits
	logic out_load;
	assign out_load = (state_q == S_OUT) && !cfg_wr && (!m_tvalid || m_tready);

	assign s_tready = (state_q == S_IDLE);
	assign m_tdata = m_data_q;

	logic last_idx;
	assign last_idx = ({1'b0, idx_q} + 1'b1) >= (AW+1)'(cnt_q);

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		raddr = idx_q;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
				wdata.size = (idx_q == '0) ? pool_q : '0;
			end
			S_CHK: begin
				if (!func_q) begin
					if (!rdata.used && rdata.size >= req_q) begin
						we = (rdata.size == req_q) ||
							(cnt_q < CW'(MAX_SEGMENTS));
						wdata.used = 1'b1;
						wdata.size = req_q;
					end
				end else if (acc_q == {1'b0, boff_q} && rdata.used) begin
					we = 1'b1;
					wdata.used = 1'b0;
					wdata.size = rdata.size;
				end
			end
			// split: move entries from tgt+1 up, carrying hold_q
			S_SPL_WR: begin
				we = 1'b1;
				wdata = hold_q;
			end
			S_MRG_CHK: begin
				if (prev_ok_q && !prev_q.used && !rdata.used) begin
					we = 1'b1;
					waddr = tgt_q;
					wdata.size = prev_q.size + rdata.size;
				end
			end
			// entries past the count are don't care, the top one is left stale
			S_SH_WR: begin
				we = 1'b1;
				waddr = idx_q - 1'b1;
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			idx_q <= '0;
			cnt_q <= CW'(1);
			pool_q <= POOL_MAX[SW-1:0];
			used_q <= '0;
			m_tvalid <= 1'b0;
			m_data_q <= '0;
		end else begin
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (cfg_wr) begin
				pool_q <= cfg_v;
				used_q <= '0;
				cnt_q <= CW'(1);
				idx_q <= '0;
				state_q <= S_CLR;
			end else begin
				case (state_q)
					S_CLR: begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == AW'(MAX_SEGMENTS - 1)) begin
							idx_q <= '0;
							state_q <= S_IDLE;
						end
					end
					S_IDLE: if (s_tvalid && s_tready) begin
						func_q <= s_tuser;
						req_q <= s_tdata[SW-1:0];
						boff_q <= s_tdata[SW+15:SW];
						acc_q <= '0;
						idx_q <= '0;
						res_off_q <= '0;
						if (!s_tuser && s_tdata[SW-1:0] == '0) begin
							res_st_q <= ffsa_pkg::ST_ZERO;
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
					S_RD: state_q <= S_CHK;
					S_CHK: begin
						tgt_q <= idx_q;
						if (!func_q && !rdata.used && rdata.size >= req_q) begin
							if (rdata.size == req_q) begin
								used_q <= used_q + req_q;
								res_st_q <= ffsa_pkg::ST_OK;
								res_off_q <= acc_q[15:0];
								state_q <= S_OUT;
							end else if (cnt_q >= CW'(MAX_SEGMENTS)) begin
								res_st_q <= ffsa_pkg::ST_FULL;
								state_q <= S_OUT;
							end else begin
								used_q <= used_q + req_q;
								res_st_q <= ffsa_pkg::ST_OK;
								res_off_q <= acc_q[15:0];
								hold_q <= '{used: 1'b0, size: rdata.size - req_q};
								idx_q <= idx_q + 1'b1;
								state_q <= S_SPL_RD;
							end
						end else if (func_q && acc_q == {1'b0, boff_q}) begin
							if (rdata.used) begin
								used_q <= used_q - rdata.size;
								res_st_q <= ffsa_pkg::ST_OK;
								idx_q <= '0;
								prev_ok_q <= 1'b0;
								state_q <= S_MRG_RD;
							end else begin
								res_st_q <= ffsa_pkg::ST_NOTFOUND;
								state_q <= S_OUT;
							end
						end else if (last_idx) begin
							res_st_q <= func_q ? ffsa_pkg::ST_NOTFOUND : ffsa_pkg::ST_NOFIT;
							state_q <= S_OUT;
						end else begin
							acc_q <= acc_q + rdata.size;
							idx_q <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
					S_SPL_RD: state_q <= S_SPL_WR;
					S_SPL_WR: begin
						hold_q <= rdata;
						if ({1'b0, idx_q} >= (AW+1)'(cnt_q)) begin
							cnt_q <= cnt_q + 1'b1;
							state_q <= S_OUT;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SPL_RD;
						end
					end
					// coalesce pass: tgt_q is the running merge target
					S_MRG_RD: state_q <= S_MRG_CHK;
					S_MRG_CHK: begin
						if (prev_ok_q && !prev_q.used && !rdata.used) begin
							prev_q.size <= prev_q.size + rdata.size;
							// merging the top entry needs no move
							if (last_idx) begin
								cnt_q <= cnt_q - 1'b1;
								state_q <= S_OUT;
							end else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_SH_RD;
							end
						end else begin
							prev_q <= rdata;
							prev_ok_q <= 1'b1;
							tgt_q <= idx_q;
							if (last_idx) state_q <= S_OUT;
							else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_MRG_RD;
							end
						end
					end
					S_SH_RD: state_q <= S_SH_WR;
					S_SH_WR: begin
						if (last_idx) begin
							cnt_q <= cnt_q - 1'b1;
							idx_q <= tgt_q + 1'b1;
							if ({1'b0, tgt_q} + 2'd2 >= (AW+1)'(cnt_q)) state_q <= S_OUT;
							else state_q <= S_MRG_RD;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_SH_RD;
						end
					end
					S_OUT: begin
						if (out_load) begin
							m_data_q <= {3'b000, SW'(pool_q - used_q), used_q, res_st_q,
								res_off_q};
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// shifting always reads one place beyond the write address
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SH_WR) |-> (idx_q != '0))
		else $error("shift below entry zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CW'(MAX_SEGMENTS)))
		else $error("segment count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= pool_q)
		else $error("used units exceed pool");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped or changed while held");
endmodule
`default_nettype wire

/* rtl/ffsa_table.sv */
`default_nettype none
// segment table memory, one write port and one registered read port
module ffsa_table #(
	parameter int DEPTH = ffsa_pkg::MAX_SEGMENTS_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire ffsa_pkg::seg_t wdata,
	input wire logic [AW-1:0] raddr,
	output ffsa_pkg::seg_t rdata
);
	ffsa_pkg::seg_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
	localparam int SEGS = ffsa_pkg::MAX_SEGMENTS_DEF;
	localparam int POOL_DEF = ffsa_pkg::POOL_UNITS_DEF;
	localparam int SIZE_BITS = ffsa_pkg::SIZE_W;
	localparam int OFF_BITS = ffsa_pkg::OFF_W;
	localparam int STATUS_BITS = ffsa_pkg::STATUS_W;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 4 * SEGS + 20;
	localparam logic [2:0] ADDR_POOL_SIZE = 3'd0;

	// one allocator answer, as carried on m_tdata
	typedef struct packed {
		logic [SIZE_BITS-1:0] free_total;
		logic [SIZE_BITS-1:0] used_total;
		logic [STATUS_BITS-1:0] status;
		logic [OFF_BITS-1:0] seg_offset;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// alloc_size, block_offset, zero padding
	logic [39:0] s_tdata = '0;
	// func
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// segment_offset, status, used_total, free_total, zero padding
	logic [55:0] m_tdata;

	first_fit_segment_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the segment table
	logic [SIZE_BITS-1:0] shadow_size [SEGS];
	logic shadow_used [SEGS];
	int shadow_count;
	int shadow_used_units;
	int shadow_pool;

	answer_t pending_answers [$];
	int live_offsets [$];
	int errors = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void reset_shadow(input int units);
		for (int k = 0; k < SEGS; k++) begin
			shadow_size[k] = '0;
			shadow_used[k] = 1'b0;
		end
		shadow_size[0] = units[SIZE_BITS-1:0];
		shadow_count = 1;
		shadow_used_units = 0;
		shadow_pool = units;
	endfunction

	// drop entry idx, moving later entries down
	function automatic void drop_entry(input int idx);
		for (int k = idx; k + 1 < shadow_count; k++) begin
			shadow_size[k] = shadow_size[k+1];
			shadow_used[k] = shadow_used[k+1];
		end
		shadow_count--;
		shadow_size[shadow_count] = '0;
		shadow_used[shadow_count] = 1'b0;
	endfunction

	function automatic answer_t first_fit_predict(input logic func, input int req, input int boff);
		answer_t a;
		int i;
		int off;
		off = 0;
		a.seg_offset = '0;
		if (func == ffsa_pkg::FUNC_ALLOC) begin
			if (req == 0) begin
				a.status = ffsa_pkg::ST_ZERO;
			end else begin
				for (i = 0; i < shadow_count; i++) begin
					if (!shadow_used[i] && int'(shadow_size[i]) >= req)
						break;
					off += shadow_size[i];
				end
				if (i >= shadow_count) begin
					a.status = ffsa_pkg::ST_NOFIT;
				end else if (int'(shadow_size[i]) > req && shadow_count >= SEGS) begin
					a.status = ffsa_pkg::ST_FULL;
				end else begin
					if (int'(shadow_size[i]) > req) begin
						for (int k = shadow_count; k > i + 1; k--) begin
							shadow_size[k] = shadow_size[k-1];
							shadow_used[k] = shadow_used[k-1];
						end
						shadow_size[i+1] = shadow_size[i] - req[SIZE_BITS-1:0];
						shadow_used[i+1] = 1'b0;
						shadow_size[i] = req[SIZE_BITS-1:0];
						shadow_count++;
					end
					shadow_used[i] = 1'b1;
					shadow_used_units += req;
					a.status = ffsa_pkg::ST_OK;
					a.seg_offset = off[OFF_BITS-1:0];
				end
			end
		end else begin
			for (i = 0; i < shadow_count; i++) begin
				if (off == boff)
					break;
				off += shadow_size[i];
			end
			if (i >= shadow_count || !shadow_used[i]) begin
				a.status = ffsa_pkg::ST_NOTFOUND;
			end else begin
				shadow_used[i] = 1'b0;
				shadow_used_units -= shadow_size[i];
				// merge free neighbours
				i = 0;
				while (i + 1 < shadow_count) begin
					if (!shadow_used[i] && !shadow_used[i+1]) begin
						shadow_size[i] = shadow_size[i] + shadow_size[i+1];
						drop_entry(i + 1);
					end else begin
						i++;
					end
				end
				a.status = ffsa_pkg::ST_OK;
			end
		end
		a.used_total = shadow_used_units[SIZE_BITS-1:0];
		a.free_total = SIZE_BITS'(shadow_pool - shadow_used_units);
		return a;
	endfunction

	// offer one operation, wait until it is accepted, and queue its predicted answer
	task automatic send_op(input logic func, input int req, input int boff);
		answer_t a;
		int req_f;
		int boff_f;
		req_f = int'(req[SIZE_BITS-1:0]);
		boff_f = int'(boff[OFF_BITS-1:0]);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {7'b0, boff[OFF_BITS-1:0], req[SIZE_BITS-1:0]};
		do @(posedge clk); while (!s_tready);
		a = first_fit_predict(func, req_f, boff_f);
		pending_answers = {pending_answers, a};
		// keep track of live blocks for well-formed frees
		if (a.status == ffsa_pkg::ST_OK) begin
			if (func == ffsa_pkg::FUNC_ALLOC) begin
				live_offsets = {live_offsets, int'(a.seg_offset)};
			end else begin
				foreach (live_offsets[j])
					if (live_offsets[j] == boff_f) begin
						live_offsets.delete(j);
						break;
					end
			end
		end
	endtask

	task automatic drain;
		@(posedge clk);
		s_tvalid <= 1'b0;
		wait (pending_answers.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup then access; the write lands at the access edge
	task automatic write_pool_size(input logic [31:0] value);
		int v;
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_POOL_SIZE;
		pwdata <= value;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		v = int'(value[SIZE_BITS-1:0]);
		if (v == 0)
			v = 1;
		if (v > POOL_DEF)
			v = POOL_DEF;
		reset_shadow(v);
		live_offsets.delete();
	endtask

	// result checker: each answer against the oldest prediction
	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (m_tvalid && m_tready) begin
			got = answer_t'(m_tdata[52:0]);
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result, pending", 0, 0);
			end else begin
				want = pending_answers.pop_front();
				if (got.seg_offset !== want.seg_offset)
					report_mismatch("segment_offset", got.seg_offset, want.seg_offset);
				if (got.status !== want.status)
					report_mismatch("status", got.status, want.status);
				if (got.used_total !== want.used_total)
					report_mismatch("used_total", got.used_total, want.used_total);
				if (got.free_total !== want.free_total)
					report_mismatch("free_total", got.free_total, want.free_total);
			end
		end
	end

	// receiver: long hold on request, random stall bursts otherwise while idle_on is set
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 18) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", pending_answers.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// extremes of the fields and every status but ST_FULL
	task automatic test_directed;
		send_op(ffsa_pkg::FUNC_ALLOC, 0, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 65536, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 1, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 65535);
		send_op(ffsa_pkg::FUNC_ALLOC, 1, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 2, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 3, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 1);
		send_op(ffsa_pkg::FUNC_ALLOC, 2, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 65530, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 6);
		send_op(ffsa_pkg::FUNC_FREE, 0, 3);
		send_op(ffsa_pkg::FUNC_ALLOC, 65535, 65535);
		send_op(ffsa_pkg::FUNC_FREE, 0, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 1);
		send_op(ffsa_pkg::FUNC_ALLOC, 43690, 21845);
		send_op(ffsa_pkg::FUNC_ALLOC, 21846, 43690);
	endtask

	// fill the table so that a split has no room, then exact fit
	task automatic test_table_full;
		write_pool_size(32'd100);
		for (int k = 0; k < SEGS - 1; k++)
			send_op(ffsa_pkg::FUNC_ALLOC, 1, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 1, 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 100 - (SEGS - 1), 0);
		send_op(ffsa_pkg::FUNC_ALLOC, 1, 0);
		send_op(ffsa_pkg::FUNC_FREE, 0, 5);
		send_op(ffsa_pkg::FUNC_FREE, 0, 6);
		send_op(ffsa_pkg::FUNC_ALLOC, 2, 0);
	endtask

	// mostly well-formed alloc and free traffic, some noise
	task automatic test_random(input int count, input int max_req);
		int pick;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) < 8) begin
				if (live_offsets.size() == 0 || $urandom_range(0, 1) == 0) begin
					send_op(ffsa_pkg::FUNC_ALLOC, $urandom_range(1, max_req),
						$urandom_range(0, 65535));
				end else begin
					pick = $urandom_range(0, live_offsets.size() - 1);
					send_op(ffsa_pkg::FUNC_FREE, $urandom_range(0, 65536), live_offsets[pick]);
				end
			end else begin
				case ($urandom_range(0, 3))
					0: send_op(ffsa_pkg::FUNC_ALLOC, 0, $urandom_range(0, 65535));
					1: send_op(ffsa_pkg::FUNC_ALLOC, $urandom_range(1, 65536), 0);
					2: send_op(ffsa_pkg::FUNC_FREE, 0, $urandom_range(0, 65535));
					default: send_op(ffsa_pkg::FUNC_FREE, 0, $urandom_range(0, shadow_pool));
				endcase
			end
		end
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure;
		hold_req = 1'b1;
		wait (hold_left != 0);
		hold_req = 1'b0;
		test_random(20, 64);
	endtask

	initial begin
		reset_shadow(POOL_DEF);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		write_pool_size(32'd0);
		test_random(20, 2);
		write_pool_size(32'h1FFFF);
		test_random(350, 4096);
		test_backpressure();
		write_pool_size(32'd1000);
		test_random(250, 60);
		write_pool_size(32'd16);
		test_random(100, 5);
		write_pool_size(32'd65536);
		idle_on = 1'b0;
		test_random(150, 2048);
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
